>>> design/stc_pkg.sv
// ============================================================================
// stc_pkg - shared types and constants for the source token classifier
// Token kinds, character codes, keyword table, item types and the helper
// functions used by the lexer and the top level.
// ============================================================================
package stc_pkg;

    // Width of the token length counter; counts saturate at all ones.
    localparam int LENGTH_WIDTH = 16;
    localparam int TOKEN_LEN_W  = 16;
    localparam int KIND_W       = 5;
    localparam int CHAR_W       = 8;
    localparam int PREFIX_BYTES = 7;
    localparam int PREFIX_W     = PREFIX_BYTES * CHAR_W;
    localparam int KW_COUNT     = 8;

    // Result queue depth
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);

    // Token kinds
    localparam logic [KIND_W-1:0] K_SPACE   = 5'd0;
    localparam logic [KIND_W-1:0] K_VAR_S   = 5'd1;
    localparam logic [KIND_W-1:0] K_VAR_A   = 5'd2;
    localparam logic [KIND_W-1:0] K_VAR_H   = 5'd3;
    localparam logic [KIND_W-1:0] K_SEMI    = 5'd4;
    localparam logic [KIND_W-1:0] K_OPEN    = 5'd5;
    localparam logic [KIND_W-1:0] K_CLOSE   = 5'd6;
    localparam logic [KIND_W-1:0] K_IDENT   = 5'd7;
    localparam logic [KIND_W-1:0] K_PKG     = 5'd8;
    localparam logic [KIND_W-1:0] K_KW_BASE = 5'd9;
    localparam logic [KIND_W-1:0] K_ERROR   = 5'd17;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT     = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF     = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_US     = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;
    localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

    // Keywords packed first byte lowest: any do dbl int my package str sub
    localparam logic [PREFIX_W-1:0] KW_TEXT [KW_COUNT] = '{
        56'h00000000796E61,
        56'h00000000006F64,
        56'h000000006C6264,
        56'h00000000746E69,
        56'h0000000000796D,
        56'h6567616B636170,
        56'h00000000727473,
        56'h00000000627573
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd2, 3'd3, 3'd3, 3'd2, 3'd7, 3'd3, 3'd3
    };

    typedef logic [LENGTH_WIDTH-1:0] len_t;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [TOKEN_LEN_W-1:0] length;
        logic                   last;
    } token_t;

    // Up to two tokens per byte
    typedef struct packed {
        logic [1:0] cnt;
        token_t     tok0;
        token_t     tok1;
    } step_res_t;

    typedef struct packed {
        logic idle;
        logic err;
    } lex_stat_t;

    function automatic logic is_alnum(input logic [CHAR_W-1:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_word_start(input logic [CHAR_W-1:0] b);
        return (b == CH_US) || (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_space_start(input logic [CHAR_W-1:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_FF) ||
               (b == CH_CR);
    endfunction

    function automatic logic is_space_cont(input logic [CHAR_W-1:0] b);
        return is_space_start(b) || (b == CH_VT);
    endfunction

    // Saturating add of a small step
    function automatic len_t len_inc(input len_t v, input logic [1:0] d);
        logic [LENGTH_WIDTH:0] sum;
        sum = {1'b0, v} + (LENGTH_WIDTH + 1)'(d);
        if (sum[LENGTH_WIDTH])
            return '1;
        return sum[LENGTH_WIDTH-1:0];
    endfunction

    // Keyword kind of the current word, identifier when none matches
    function automatic logic [KIND_W-1:0] word_kind(input len_t len,
                                                    input logic [PREFIX_W-1:0] prefix);
        logic [KIND_W-1:0] k;
        k = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (len == LENGTH_WIDTH'(KW_LEN[i]) && prefix == KW_TEXT[i])
                k = K_KW_BASE + KIND_W'(i);
        end
        return k;
    endfunction

endpackage

>>> design/stc_lexer.sv
// ============================================================================
// stc_lexer - lexer state and per-byte token decision
// Holds the scan mode, run length, word prefix and sticky error; classifies
// one byte per enabled cycle and reports up to two finished tokens.
// ============================================================================
module stc_lexer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step_en,
    input  logic [7:0]                  char_in,
    input  logic                        eos_in,
    output stc_pkg::step_res_t          res,
    output stc_pkg::lex_stat_t          stat
);
    import stc_pkg::*;

    localparam logic [3:0] M_IDLE  = 4'd0;
    localparam logic [3:0] M_SPACE = 4'd1;
    localparam logic [3:0] M_VS    = 4'd2;
    localparam logic [3:0] M_VA    = 4'd3;
    localparam logic [3:0] M_VH    = 4'd4;
    localparam logic [3:0] M_WORD  = 4'd5;
    localparam logic [3:0] M_WC1   = 4'd6;
    localparam logic [3:0] M_WC2   = 4'd7;
    localparam logic [3:0] M_PKG   = 4'd8;
    localparam logic [3:0] M_PC1   = 4'd9;
    localparam logic [3:0] M_PC2   = 4'd10;

    logic [3:0]          mode_reg, mode_next;
    len_t                len_reg, len_next;
    logic [PREFIX_W-1:0] prefix_reg, prefix_next;
    logic                err_reg, err_next;
    logic                do_start;
    logic                do_error;
    logic [KIND_W-1:0]   cur_kind;
    logic [KIND_W-1:0]   var_kind;

    // Append one token to the result pair
    function automatic step_res_t push(input step_res_t r, input logic [KIND_W-1:0] k,
                                       input len_t l);
        step_res_t o;
        o = r;
        if (r.cnt == 2'd0)
        begin
            o.tok0.kind   = k;
            o.tok0.length = TOKEN_LEN_W'(l);
            o.tok0.last   = 1'b0;
        end
        else
        begin
            o.tok1.kind   = k;
            o.tok1.length = TOKEN_LEN_W'(l);
            o.tok1.last   = 1'b0;
        end
        o.cnt = r.cnt + 2'd1;
        return o;
    endfunction

    assign cur_kind = word_kind(len_reg, prefix_reg);
    assign var_kind = (mode_reg == M_VS) ? K_VAR_S : ((mode_reg == M_VA) ? K_VAR_A : K_VAR_H);

    always_comb
    begin
        mode_next   = mode_reg;
        len_next    = len_reg;
        prefix_next = prefix_reg;
        err_next    = err_reg;
        res         = '0;
        do_start    = 1'b0;
        do_error    = 1'b0;

        if (!err_reg)
        begin
            unique case (mode_reg)
                M_SPACE:
                begin
                    if (is_space_cont(char_in))
                        len_next = len_inc(len_reg, 2'd1);
                    else
                    begin
                        res      = push(res, K_SPACE, len_reg);
                        do_start = 1'b1;
                    end
                end
                M_VS, M_VA, M_VH:
                begin
                    if (char_in == CH_US || is_alnum(char_in))
                        len_next = len_inc(len_reg, 2'd1);
                    else
                    begin
                        res      = push(res, var_kind, len_reg);
                        do_start = 1'b1;
                    end
                end
                M_WORD:
                begin
                    if (is_alnum(char_in))
                    begin
                        if (len_reg < LENGTH_WIDTH'(PREFIX_BYTES))
                            prefix_next[{len_reg[2:0], 3'b000} +: CHAR_W] = char_in;
                        len_next = len_inc(len_reg, 2'd1);
                    end
                    else if (cur_kind == K_IDENT && char_in == CH_COLON)
                        mode_next = M_WC1;
                    else
                    begin
                        res      = push(res, cur_kind, len_reg);
                        do_start = 1'b1;
                    end
                end
                M_PKG:
                begin
                    if (is_alnum(char_in))
                        len_next = len_inc(len_reg, 2'd1);
                    else if (char_in == CH_COLON)
                        mode_next = M_PC1;
                    else
                    begin
                        res      = push(res, K_PKG, len_reg);
                        do_start = 1'b1;
                    end
                end
                M_WC1, M_PC1:
                begin
                    if (char_in == CH_COLON)
                        mode_next = (mode_reg == M_WC1) ? M_WC2 : M_PC2;
                    else
                    begin
                        res      = push(res, (mode_reg == M_WC1) ? K_IDENT : K_PKG, len_reg);
                        do_error = 1'b1;
                    end
                end
                M_WC2, M_PC2:
                begin
                    if (is_alnum(char_in))
                    begin
                        len_next  = len_inc(len_reg, 2'd3);
                        mode_next = M_PKG;
                    end
                    else
                    begin
                        res      = push(res, (mode_reg == M_WC2) ? K_IDENT : K_PKG, len_reg);
                        do_error = 1'b1;
                    end
                end
                default:
                    do_start = 1'b1;
            endcase

            // Start a new token on this byte
            if (do_start)
            begin
                mode_next   = M_IDLE;
                len_next    = LENGTH_WIDTH'(1);
                prefix_next = '0;
                priority if (is_space_start(char_in))
                    mode_next = M_SPACE;
                else if (char_in == CH_DOLLAR)
                    mode_next = M_VS;
                else if (char_in == CH_AT)
                    mode_next = M_VA;
                else if (char_in == CH_PCT)
                    mode_next = M_VH;
                else if (char_in == CH_SEMI)
                    res = push(res, K_SEMI, LENGTH_WIDTH'(1));
                else if (char_in == CH_LBRACE)
                    res = push(res, K_OPEN, LENGTH_WIDTH'(1));
                else if (char_in == CH_RBRACE)
                    res = push(res, K_CLOSE, LENGTH_WIDTH'(1));
                else if (is_word_start(char_in))
                begin
                    mode_next   = M_WORD;
                    prefix_next = PREFIX_W'(char_in);
                end
                else
                    do_error = 1'b1;
            end

            if (do_error)
            begin
                res       = push(res, K_ERROR, LENGTH_WIDTH'(1));
                err_next  = 1'b1;
                mode_next = M_IDLE;
            end
        end

        // End of source: flush the pending token, then return to reset
        if (eos_in)
        begin
            if (!err_next)
            begin
                unique case (mode_next)
                    M_SPACE: res = push(res, K_SPACE, len_next);
                    M_VS:    res = push(res, K_VAR_S, len_next);
                    M_VA:    res = push(res, K_VAR_A, len_next);
                    M_VH:    res = push(res, K_VAR_H, len_next);
                    M_WORD:  res = push(res, word_kind(len_next, prefix_next), len_next);
                    M_PKG:   res = push(res, K_PKG, len_next);
                    M_WC1, M_WC2:
                    begin
                        res = push(res, K_IDENT, len_next);
                        res = push(res, K_ERROR, LENGTH_WIDTH'(1));
                    end
                    M_PC1, M_PC2:
                    begin
                        res = push(res, K_PKG, len_next);
                        res = push(res, K_ERROR, LENGTH_WIDTH'(1));
                    end
                    default: ;
                endcase
            end
            mode_next   = M_IDLE;
            len_next    = '0;
            prefix_next = '0;
            err_next    = 1'b0;
        end

        // Mark the final token of this byte
        if (res.cnt == 2'd1)
            res.tok0.last = 1'b1;
        else if (res.cnt == 2'd2)
            res.tok1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            len_reg    <= '0;
            prefix_reg <= '0;
            err_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg   <= mode_next;
            len_reg    <= len_next;
            prefix_reg <= prefix_next;
            err_reg    <= err_next;
        end
    end

    assign stat.idle = (mode_reg == M_IDLE);
    assign stat.err  = err_reg;

endmodule

>>> design/stc_result_fifo.sv
// ============================================================================
// stc_result_fifo - small result queue
// Takes zero, one or two tokens per cycle; one out per rd_en when not empty.
// ============================================================================
module stc_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        wr_cnt,
    input  stc_pkg::token_t   wr_tok0,
    input  stc_pkg::token_t   wr_tok1,
    input  logic              rd_en,
    output stc_pkg::token_t   head,
    output logic              not_empty,
    output logic              room
);
    import stc_pkg::*;

    token_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg, count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_p1;
    logic                  rd_fire;

    assign rd_fire     = rd_en && not_empty;
    assign wr_ptr_p1   = wr_ptr_reg + FIFO_PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(wr_cnt);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(rd_fire);
    assign count_next  = count_reg + (FIFO_PTR_W + 1)'(wr_cnt) - (FIFO_PTR_W + 1)'(rd_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
            mem[wr_ptr_reg] <= wr_tok0;
        if (wr_cnt == 2'd2)
            mem[wr_ptr_p1] <= wr_tok1;
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    // Room for a full pair regardless of this cycle's read
    assign room      = (count_reg <= (FIFO_PTR_W + 1)'(FIFO_DEPTH - 2));

endmodule

>>> design/source_token_classifier.sv
// ============================================================================
// source_token_classifier - streaming source tokenizer
// Splits a byte stream of source text into tokens and reports kind and length.
// ============================================================================
// One source byte enters per s_ tvalid/tready handshake, with s_tlast marking
// the final byte of the source. Each token leaves as one m_ item once
// its end is known: the first byte outside it, or the last byte of the source.
// A byte may finish two tokens (for example a word ended by ';', or a word left
// dangling before a broken "::" separator, which also yields an error token);
// m_tlast marks the final token caused by a byte. After an error token the
// block swallows bytes silently until s_tlast, which clears the error. Bytes
// are accepted one per cycle as long as output items drain at the same pace:
// a byte is held in the input register, is classified in a single pass
// into the four-entry result queue, and its tokens leave it on m_. The
// single-token output port sets the sustained rate: a byte giving two tokens
// takes two output items, and the queue stops taking bytes when it has fewer
// than two free entries. Lengths saturate at 65535.
// ============================================================================
module source_token_classifier (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [4:0] token_kind, [20:5] token_length, [23:21] zero
    output logic        m_tlast    // last_of_run
);
    import stc_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       step_fire;
    logic       fifo_room;
    logic [1:0] wr_cnt;
    step_res_t  step_res;
    lex_stat_t  lex_stat;
    token_t     head_tok;

    // Advance the input register whenever the lexer takes its byte
    assign step_fire = in_valid_reg && fifo_room;
    assign s_tready  = !in_valid_reg || fifo_room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    stc_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_fire),
        .char_in (in_byte_reg),
        .eos_in  (in_last_reg),
        .res     (step_res),
        .stat    (lex_stat)
    );

    // Drop the lexer's tokens unless the byte is really taken
    assign wr_cnt = step_fire ? step_res.cnt : 2'd0;

    stc_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_cnt    (wr_cnt),
        .wr_tok0   (step_res.tok0),
        .wr_tok1   (step_res.tok1),
        .rd_en     (m_tready),
        .head      (head_tok),
        .not_empty (m_tvalid),
        .room      (fifo_room)
    );

    assign m_tdata = {3'b000, head_tok.length, head_tok.kind};
    assign m_tlast = head_tok.last;

    // A byte finishes at most two tokens
    assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |-> step_res.cnt != 2'd3)
        else $error("lexer reported more than two tokens for one byte");

    // Of a token pair only the second closes the byte
    assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && step_res.cnt == 2'd2 |-> !step_res.tok0.last && step_res.tok1.last)
        else $error("wrong last marking on a token pair");

    // End of source returns the lexer to its reset state
    assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && in_last_reg |=> lex_stat.idle && !lex_stat.err)
        else $error("lexer not idle after end of source");

    // An error token latches the error unless the source ends with it
    assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && !in_last_reg &&
        ((step_res.cnt == 2'd1 && step_res.tok0.kind == K_ERROR) ||
         (step_res.cnt == 2'd2 && step_res.tok1.kind == K_ERROR)) |=> lex_stat.err)
        else $error("error token without latched error");

    // A byte waiting in the input register holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step_fire |=> in_valid_reg && $stable(in_byte_reg)
                                       && $stable(in_last_reg))
        else $error("pending byte lost or changed");

endmodule
